// ----- hw/rtl/lkr_pkg.sv -----
// ----------------------------------------------------------------------------
// lkr_pkg
// Types and constants shared by the link keepalive/reconnect supervisor.
// ----------------------------------------------------------------------------
package lkr_pkg;

   typedef enum logic [2:0] {
      ST_DX = 3'd0,
      ST_RW = 3'd1,
      ST_CN = 3'd2,
      ST_UP = 3'd3,
      ST_PP = 3'd4
   } link_state_type;

   typedef enum logic [3:0] {
      NT_NONE       = 4'd0,
      NT_CONNECTING = 4'd1,
      NT_CONNECTED  = 4'd2,
      NT_RETRY      = 4'd3,
      NT_CANCELLED  = 4'd4,
      NT_CLOSED     = 4'd5,
      NT_LOST       = 4'd6,
      NT_PING       = 4'd7,
      NT_TIMEOUT    = 4'd8,
      NT_REJ_UP     = 4'd9,
      NT_REJ_BUSY   = 4'd10,
      NT_REJ_DOWN   = 4'd11,
      NT_IGNORED    = 4'd12
   } notice_type;

   localparam logic [2:0] KIND_CONNECT    = 3'd0;
   localparam logic [2:0] KIND_DISCONNECT = 3'd1;
   localparam logic [2:0] KIND_ATTEMPT    = 3'd2;
   localparam logic [2:0] KIND_BACKOFF    = 3'd3;
   localparam logic [2:0] KIND_READ       = 3'd4;

   localparam logic [1:0] RD_DATA    = 2'd0;
   localparam logic [1:0] RD_TIMEOUT = 2'd1;
   localparam logic [1:0] RD_CLOSED  = 2'd2;

   localparam logic [2:0] CSR_PING_FIRST     = 3'd0;
   localparam logic [2:0] CSR_PING_STEP      = 3'd1;
   localparam logic [2:0] CSR_PING_LIMIT     = 3'd2;
   localparam logic [2:0] CSR_BACKOFF_BASE   = 3'd3;
   localparam logic [2:0] CSR_BACKOFF_FACTOR = 3'd4;
   localparam logic [2:0] CSR_BACKOFF_MAX    = 3'd5;

   localparam logic [16:0] RST_PING_FIRST     = 17'd150;
   localparam logic [16:0] RST_PING_STEP      = 17'd5;
   localparam logic [16:0] RST_PING_LIMIT     = 17'd300;
   localparam logic [16:0] RST_BACKOFF_BASE   = 17'd4;
   localparam logic [5:0]  RST_BACKOFF_FACTOR = 6'd2;
   localparam logic [16:0] RST_BACKOFF_MAX    = 17'd86400;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [2:0] kind;
      logic       attempt_ok;
      logic [1:0] read_outcome;
   } req_type;

   typedef struct packed {
      logic [2:0]  link_state;
      logic [3:0]  notice;
      logic [17:0] value;
      logic        link_up;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [16:0] ping_first;
      logic [16:0] ping_step;
      logic [16:0] ping_limit;
      logic [16:0] backoff_base;
      logic [5:0]  backoff_factor;
      logic [16:0] backoff_max;
   } cfg_type;

   typedef struct packed {
      logic push;
      logic pair;
   } push_type;

endpackage

// ----- hw/rtl/lkr_csr.sv -----
// ----------------------------------------------------------------------------
// lkr_csr
// Configuration register file for the keepalive and backoff settings.
// ----------------------------------------------------------------------------
module lkr_csr
   import lkr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PING_FIRST:     cfg_in.ping_first     = csr_wdata;
            CSR_PING_STEP:      cfg_in.ping_step      = csr_wdata;
            CSR_PING_LIMIT:     cfg_in.ping_limit     = csr_wdata;
            CSR_BACKOFF_BASE:   cfg_in.backoff_base   = csr_wdata;
            CSR_BACKOFF_FACTOR: cfg_in.backoff_factor = csr_wdata[5:0];
            CSR_BACKOFF_MAX:    cfg_in.backoff_max    = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ping_first     <= RST_PING_FIRST;
         cfg_ff.ping_step      <= RST_PING_STEP;
         cfg_ff.ping_limit     <= RST_PING_LIMIT;
         cfg_ff.backoff_base   <= RST_BACKOFF_BASE;
         cfg_ff.backoff_factor <= RST_BACKOFF_FACTOR;
         cfg_ff.backoff_max    <= RST_BACKOFF_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/lkr_engine.sv -----
// ----------------------------------------------------------------------------
// lkr_engine
// Input register, link state machine, silence counter and retry delay.
// ----------------------------------------------------------------------------
module lkr_engine
   import lkr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  cfg_type  cfg,
   input  logic     room,
   output push_type push,
   output rsp_type  rsp0,
   output rsp_type  rsp1
);

   logic           in_vld_ff, in_vld_in;
   req_type        in_req_ff, in_req_in;
   link_state_type state_ff, state_in;
   logic [17:0]    sil_ff, sil_in;
   logic [16:0]    dly_ff, dly_in;

   logic           proc;
   logic           accept;
   logic           pair;
   link_state_type ns;
   logic [22:0]    prod;
   logic [16:0]    dly_next;
   logic [18:0]    sil_sum;
   logic [17:0]    sil_next;

   assign proc      = in_vld_ff & room;
   assign req_stall = in_vld_ff & ~room;
   assign accept    = req_valid & ~req_stall;

   assign prod     = 23'(cfg.backoff_factor) * 23'(dly_ff);
   assign dly_next = (dly_ff == 17'd0) ? cfg.backoff_base :
                     (prod > 23'(cfg.backoff_max)) ? cfg.backoff_max : prod[16:0];
   assign sil_sum  = 19'(sil_ff) + 19'(cfg.ping_step);
   assign sil_next = (state_ff == ST_UP) ? 18'(cfg.ping_first) :
                     (sil_sum[18] ? {18{1'b1}} : sil_sum[17:0]);

   always_comb begin
      in_vld_in = in_vld_ff;
      in_req_in = in_req_ff;
      if (accept) begin
         in_vld_in = 1'b1;
         in_req_in = req_data;
      end else if (proc) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      ns          = state_ff;
      sil_in      = sil_ff;
      dly_in      = dly_ff;
      pair        = 1'b0;
      rsp0        = '0;
      rsp0.notice = NT_IGNORED;
      rsp0.last   = 1'b1;
      case (in_req_ff.kind)
         KIND_CONNECT: begin
            if (state_ff inside {ST_DX, ST_RW}) begin
               ns          = ST_CN;
               rsp0.notice = NT_CONNECTING;
            end else if (state_ff == ST_CN) begin
               rsp0.notice = NT_REJ_BUSY;
            end else begin
               rsp0.notice = NT_REJ_UP;
            end
         end
         KIND_DISCONNECT: begin
            if (state_ff == ST_DX) begin
               rsp0.notice = NT_REJ_DOWN;
            end else if (state_ff inside {ST_RW, ST_CN}) begin
               ns          = ST_DX;
               rsp0.notice = NT_CANCELLED;
            end else begin
               ns          = ST_DX;
               rsp0.notice = NT_CLOSED;
            end
         end
         KIND_ATTEMPT: begin
            if (state_ff == ST_CN) begin
               if (in_req_ff.attempt_ok) begin
                  ns          = ST_UP;
                  dly_in      = '0;
                  rsp0.notice = NT_CONNECTED;
               end else begin
                  ns          = ST_RW;
                  dly_in      = dly_next;
                  rsp0.notice = NT_RETRY;
                  rsp0.value  = 18'(dly_next);
               end
            end
         end
         KIND_BACKOFF: begin
            if (state_ff == ST_RW) begin
               ns          = ST_CN;
               rsp0.notice = NT_CONNECTING;
            end
         end
         KIND_READ: begin
            if (state_ff inside {ST_UP, ST_PP}) begin
               case (in_req_ff.read_outcome)
                  RD_CLOSED: begin
                     ns          = ST_CN;
                     rsp0.notice = NT_LOST;
                  end
                  RD_DATA: begin
                     if (state_ff == ST_PP) begin
                        ns          = ST_UP;
                        sil_in      = '0;
                        rsp0.notice = NT_PING;
                     end else begin
                        rsp0.notice = NT_NONE;
                     end
                  end
                  RD_TIMEOUT: begin
                     sil_in      = sil_next;
                     rsp0.notice = NT_PING;
                     rsp0.value  = sil_next;
                     if (sil_next >= 18'(cfg.ping_limit)) begin
                        ns   = ST_CN;
                        pair = 1'b1;
                     end else begin
                        ns = ST_PP;
                     end
                  end
                  default: rsp0.notice = NT_IGNORED;
               endcase
            end
         end
         default: rsp0.notice = NT_IGNORED;
      endcase

      rsp1            = '0;
      rsp1.link_state = ST_CN;
      rsp1.notice     = NT_TIMEOUT;
      rsp1.value      = sil_next;
      rsp1.link_up    = 1'b0;
      rsp1.last       = 1'b1;

      if (pair) begin
         rsp0.link_state = ST_PP;
         rsp0.link_up    = 1'b1;
         rsp0.last       = 1'b0;
      end else begin
         rsp0.link_state = ns;
         rsp0.link_up    = (ns == ST_UP) || (ns == ST_PP);
      end

      state_in  = proc ? ns : state_ff;
      if (!proc) begin
         sil_in = sil_ff;
         dly_in = dly_ff;
      end
      push.push = proc;
      push.pair = proc & pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DX;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         sil_ff    <= '0;
         dly_ff    <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         sil_ff    <= sil_in;
         dly_ff    <= dly_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff <= in_req_in;
   end

endmodule

// ----- hw/rtl/lkr_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// lkr_rsp_queue
// Small result queue taking one or two results per cycle, giving one unless stalled.
// ----------------------------------------------------------------------------
module lkr_rsp_queue
   import lkr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  rsp_type  rsp0,
   input  rsp_type  rsp1,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   rsp_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;
   logic [QPTR_W-1:0]   wr_ptr_nx;
   logic                pop;
   logic [QPTR_W:0]     n_push;

   assign wr_ptr_nx = wr_ptr_ff + 1'b1;
   assign room      = cnt_ff <= (QPTR_W+1)'(QUEUE_DEPTH - 2);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid & ~rsp_stall;
   assign n_push    = push.pair ? (QPTR_W+1)'(2) :
                      (push.push ? (QPTR_W+1)'(1) : '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_push[QPTR_W-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + n_push - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         mem_ff[wr_ptr_ff] <= rsp0;
      end
      if (push.pair) begin
         mem_ff[wr_ptr_nx] <= rsp1;
      end
   end

endmodule

// ----- hw/rtl/link_keepalive_reconnect_fsm_core.sv -----
// ----------------------------------------------------------------------------
// link_keepalive_reconnect_fsm_core
// Link supervisor: connect/retry backoff, keepalive silence tracking.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one event per transaction (kind, attempt_ok, read_outcome).
//   rsp_*  : one or two results per event; last marks the final one.
//            A read timeout that reaches ping_limit gives a ping result
//            followed by a timeout result.
//   csr_*  : register writes, always ready; write only while idle.
// Path: an accepted event waits in the input register, where the state is
//   updated, and its results go through the result queue to rsp_*.
// Throughput: one event per cycle while the result queue has room;
//   each result of a two-result event takes its own turn on the result port.
// Reset: state goes to disconnected, silence count and retry delay to zero,
//   registers to their defaults, result queue empties.
// Stall: results wait in a four-entry queue; once it cannot take two more,
//   the input register holds its event and req_stall rises.
// ----------------------------------------------------------------------------
module link_keepalive_reconnect_fsm_core
   import lkr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   cfg_type  cfg;
   push_type push;
   rsp_type  rsp0;
   rsp_type  rsp1;
   logic     room;

   lkr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lkr_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg),
      .room      (room),
      .push      (push),
      .rsp0      (rsp0),
      .rsp1      (rsp1)
   );

   lkr_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp0      (rsp0),
      .rsp1      (rsp1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/link_keepalive_reconnect_fsm_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_keepalive_reconnect_fsm_core_tb
// Self-checking bench for the link keepalive/reconnect supervisor.
// A scoreboard class tracks link state, silence count and retry delay, and
// queues the expected reports for each accepted event. A directed sequence
// walks the state/event table. Several register phases follow, each with
// state-aware random events and random gaps on both sides; one phase adds
// a long receiver hold-off. Every report is compared field by field.
// ----------------------------------------------------------------------------
module link_keepalive_reconnect_fsm_core_tb;
   import lkr_pkg::*;

   localparam logic [2:0] KIND_SPARE_A = 3'd5;
   localparam logic [2:0] KIND_SPARE_B = 3'd6;
   localparam logic [2:0] KIND_SPARE_C = 3'd7;
   localparam logic [1:0] RD_UNKNOWN   = 2'd3;
   localparam logic [17:0] SILENCE_MAX = 18'h3FFFF;
   localparam int PHASE_EVENTS = 300;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE       = 8;

   class link_supervisor_model;
      cfg_type        regs;
      link_state_type link_state;
      logic [17:0]    silence;
      logic [16:0]    retry_delay;
      rsp_type        pending_reports[$];
      int             mismatches;

      function new();
         regs.ping_first     = RST_PING_FIRST;
         regs.ping_step      = RST_PING_STEP;
         regs.ping_limit     = RST_PING_LIMIT;
         regs.backoff_base   = RST_BACKOFF_BASE;
         regs.backoff_factor = RST_BACKOFF_FACTOR;
         regs.backoff_max    = RST_BACKOFF_MAX;
         link_state  = ST_DX;
         silence     = '0;
         retry_delay = '0;
         mismatches  = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [16:0] data);
         case (idx)
            CSR_PING_FIRST:     regs.ping_first = data;
            CSR_PING_STEP:      regs.ping_step = data;
            CSR_PING_LIMIT:     regs.ping_limit = data;
            CSR_BACKOFF_BASE:   regs.backoff_base = data;
            CSR_BACKOFF_FACTOR: regs.backoff_factor = data[5:0];
            CSR_BACKOFF_MAX:    regs.backoff_max = data;
            default: ;
         endcase
      endfunction

      function void queue_report(notice_type nt, logic [17:0] val, logic fin);
         rsp_type r;
         r.link_state = link_state;
         r.notice     = nt;
         r.value      = val;
         r.link_up    = (link_state == ST_UP) || (link_state == ST_PP);
         r.last       = fin;
         pending_reports.push_back(r);
      endfunction

      function void advance_backoff();
         longint unsigned prod;
         if (retry_delay == 17'd0) begin
            retry_delay = regs.backoff_base;
         end else begin
            prod = 64'(regs.backoff_factor) * 64'(retry_delay);
            if (prod > 64'(regs.backoff_max))
               prod = 64'(regs.backoff_max);
            retry_delay = prod[16:0];
         end
      endfunction

      function void read_timeout();
         logic [18:0] sum;
         if (link_state == ST_UP) begin
            silence = {1'b0, regs.ping_first};
         end else begin
            sum = 19'(silence) + 19'(regs.ping_step);
            silence = (sum > 19'(SILENCE_MAX)) ? SILENCE_MAX : sum[17:0];
         end
         link_state = ST_PP;
         if (silence >= 18'(regs.ping_limit)) begin
            queue_report(NT_PING, silence, 1'b0);
            link_state = ST_CN;
            queue_report(NT_TIMEOUT, silence, 1'b1);
         end else begin
            queue_report(NT_PING, silence, 1'b1);
         end
      endfunction

      function void log_event(req_type ev);
         logic up;
         up = (link_state == ST_UP) || (link_state == ST_PP);
         case (ev.kind)
            KIND_CONNECT: begin
               if (link_state == ST_DX || link_state == ST_RW) begin
                  link_state = ST_CN;
                  queue_report(NT_CONNECTING, '0, 1'b1);
               end else if (link_state == ST_CN) begin
                  queue_report(NT_REJ_BUSY, '0, 1'b1);
               end else begin
                  queue_report(NT_REJ_UP, '0, 1'b1);
               end
            end
            KIND_DISCONNECT: begin
               if (link_state == ST_DX) begin
                  queue_report(NT_REJ_DOWN, '0, 1'b1);
               end else if (up) begin
                  link_state = ST_DX;
                  queue_report(NT_CLOSED, '0, 1'b1);
               end else begin
                  link_state = ST_DX;
                  queue_report(NT_CANCELLED, '0, 1'b1);
               end
            end
            KIND_ATTEMPT: begin
               if (link_state != ST_CN) begin
                  queue_report(NT_IGNORED, '0, 1'b1);
               end else if (ev.attempt_ok) begin
                  link_state  = ST_UP;
                  retry_delay = '0;
                  queue_report(NT_CONNECTED, '0, 1'b1);
               end else begin
                  link_state = ST_RW;
                  advance_backoff();
                  queue_report(NT_RETRY, {1'b0, retry_delay}, 1'b1);
               end
            end
            KIND_BACKOFF: begin
               if (link_state == ST_RW) begin
                  link_state = ST_CN;
                  queue_report(NT_CONNECTING, '0, 1'b1);
               end else begin
                  queue_report(NT_IGNORED, '0, 1'b1);
               end
            end
            KIND_READ: begin
               if (!up || ev.read_outcome == RD_UNKNOWN) begin
                  queue_report(NT_IGNORED, '0, 1'b1);
               end else if (ev.read_outcome == RD_CLOSED) begin
                  link_state = ST_CN;
                  queue_report(NT_LOST, '0, 1'b1);
               end else if (ev.read_outcome == RD_DATA) begin
                  if (link_state == ST_PP) begin
                     link_state = ST_UP;
                     silence    = '0;
                     queue_report(NT_PING, '0, 1'b1);
                  end else begin
                     queue_report(NT_NONE, '0, 1'b1);
                  end
               end else begin
                  read_timeout();
               end
            end
            default: queue_report(NT_IGNORED, '0, 1'b1);
         endcase
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_report(rsp_type got);
         rsp_type want;
         if (pending_reports.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected report: expected none, actual %p", $time, got);
         end else begin
            want = pending_reports.pop_front();
            compare_field("link_state", 32'(want.link_state), 32'(got.link_state));
            compare_field("notice", 32'(want.notice), 32'(got.notice));
            compare_field("value", 32'(want.value), 32'(got.value));
            compare_field("link_up", 32'(want.link_up), 32'(got.link_up));
            compare_field("last", 32'(want.last), 32'(got.last));
         end
      endfunction

      function int pending();
         return pending_reports.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;

   link_supervisor_model sup = new();
   bit no_gaps   = 1'b0;
   bit hold_rsp  = 1'b0;
   int idle_cycles = 0;

   link_keepalive_reconnect_fsm_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int draw_gap();
      if (no_gaps)
         return 0;
      return int'($urandom_range(0, 18));
   endfunction

   function automatic req_type mk(logic [2:0] kind, logic ok, logic [1:0] rd);
      req_type ev;
      ev.kind         = kind;
      ev.attempt_ok   = ok;
      ev.read_outcome = rd;
      return ev;
   endfunction

   // mostly legal events for the current state, some noise
   function automatic req_type make_event(link_state_type st);
      req_type ev;
      int pick;
      int sub;
      ev.kind         = KIND_READ;
      ev.attempt_ok   = 1'($urandom_range(0, 1));
      ev.read_outcome = 2'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      sub  = $urandom_range(0, 99);
      if (pick < 12) begin
         ev.kind         = 3'($urandom_range(0, 7));
         ev.read_outcome = 2'($urandom_range(0, 3));
         return ev;
      end
      pick = $urandom_range(0, 99);
      case (st)
         ST_DX: ev.kind = (pick < 85) ? KIND_CONNECT : KIND_DISCONNECT;
         ST_RW: begin
            if (pick < 60)      ev.kind = KIND_BACKOFF;
            else if (pick < 85) ev.kind = KIND_CONNECT;
            else                ev.kind = KIND_DISCONNECT;
         end
         ST_CN: begin
            if (pick < 80) begin
               ev.kind       = KIND_ATTEMPT;
               ev.attempt_ok = (sub < 40);
            end else if (pick < 90) begin
               ev.kind = KIND_DISCONNECT;
            end else begin
               ev.kind = KIND_CONNECT;
            end
         end
         default: begin
            if (pick < 85) begin
               ev.kind = KIND_READ;
               if (sub < 65)      ev.read_outcome = RD_TIMEOUT;
               else if (sub < 85) ev.read_outcome = RD_DATA;
               else               ev.read_outcome = RD_CLOSED;
            end else if (pick < 93) begin
               ev.kind = KIND_DISCONNECT;
            end else begin
               ev.kind = KIND_CONNECT;
            end
         end
      endcase
      return ev;
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.ping_first     = 17'($urandom_range(0, 400));
      c.ping_step      = 17'($urandom_range(0, 50));
      c.ping_limit     = 17'($urandom_range(0, 600));
      c.backoff_base   = 17'($urandom_range(1, 100));
      c.backoff_factor = 6'($urandom_range(1, 32));
      c.backoff_max    = 17'($urandom_range(1, 86400));
      return c;
   endfunction

   // called on a rising edge; returns on the edge that accepts the event
   task automatic drive_event(input req_type ev, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sup.log_event(ev);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sup.set_reg(idx, data);
   endtask

   task automatic program_regs(input cfg_type c);
      write_reg(CSR_PING_FIRST, c.ping_first);
      write_reg(CSR_PING_STEP, c.ping_step);
      write_reg(CSR_PING_LIMIT, c.ping_limit);
      write_reg(CSR_BACKOFF_BASE, c.backoff_base);
      write_reg(CSR_BACKOFF_FACTOR, {11'd0, c.backoff_factor});
      write_reg(CSR_BACKOFF_MAX, c.backoff_max);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (sup.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(input cfg_type c, input bit hold);
      drain();
      program_regs(c);
      if (hold)
         hold_rsp = 1'b1;
      for (int i = 0; i < PHASE_EVENTS; i++) begin
         if (i % 50 == 0)
            no_gaps = ($urandom_range(0, 3) == 0);
         drive_event(make_event(sup.link_state), draw_gap());
      end
      req_valid <= 1'b0;
   endtask

   // response side: random stall before each transaction, one long hold-off
   initial begin
      int n;
      forever begin
         if (hold_rsp) begin
            n = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            n = draw_gap();
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sup.check_report(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** link_keepalive_reconnect_fsm_core: FAILED **");
         $finish;
      end
   end

   initial begin
      req_type script[$];
      cfg_type c;

      script.push_back(mk(KIND_DISCONNECT, 1'b0, RD_DATA));
      script.push_back(mk(KIND_ATTEMPT, 1'b1, RD_DATA));
      script.push_back(mk(KIND_BACKOFF, 1'b0, RD_TIMEOUT));
      script.push_back(mk(KIND_READ, 1'b0, RD_TIMEOUT));
      script.push_back(mk(KIND_SPARE_A, 1'b1, RD_CLOSED));
      script.push_back(mk(KIND_SPARE_B, 1'b0, RD_UNKNOWN));
      script.push_back(mk(KIND_SPARE_C, 1'b1, RD_UNKNOWN));
      script.push_back(mk(KIND_CONNECT, 1'b0, RD_DATA));
      script.push_back(mk(KIND_CONNECT, 1'b1, RD_DATA));
      script.push_back(mk(KIND_ATTEMPT, 1'b0, RD_DATA));
      script.push_back(mk(KIND_CONNECT, 1'b0, RD_DATA));
      script.push_back(mk(KIND_ATTEMPT, 1'b0, RD_CLOSED));
      script.push_back(mk(KIND_BACKOFF, 1'b0, RD_DATA));
      script.push_back(mk(KIND_DISCONNECT, 1'b1, RD_DATA));
      script.push_back(mk(KIND_CONNECT, 1'b0, RD_DATA));
      script.push_back(mk(KIND_ATTEMPT, 1'b1, RD_DATA));
      script.push_back(mk(KIND_CONNECT, 1'b0, RD_DATA));
      script.push_back(mk(KIND_READ, 1'b0, RD_DATA));
      script.push_back(mk(KIND_READ, 1'b1, RD_UNKNOWN));
      script.push_back(mk(KIND_READ, 1'b0, RD_TIMEOUT));
      script.push_back(mk(KIND_READ, 1'b0, RD_DATA));
      script.push_back(mk(KIND_READ, 1'b0, RD_CLOSED));
      script.push_back(mk(KIND_ATTEMPT, 1'b1, RD_DATA));
      script.push_back(mk(KIND_READ, 1'b1, RD_TIMEOUT));
      script.push_back(mk(KIND_DISCONNECT, 1'b0, RD_DATA));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i])
         drive_event(script[i], draw_gap());
      req_valid <= 1'b0;

      // tight keepalive, short backoff ceiling
      c = '{ping_first: 17'd1, ping_step: 17'd1, ping_limit: 17'd4,
            backoff_base: 17'd1, backoff_factor: 6'd2, backoff_max: 17'd20};
      run_phase(c, 1'b0);
      // all minimums: every timeout trips the limit
      c = '{ping_first: 17'd0, ping_step: 17'd0, ping_limit: 17'd0,
            backoff_base: 17'd1, backoff_factor: 6'd1, backoff_max: 17'd1};
      run_phase(c, 1'b1);
      // all maximums
      c = '{ping_first: 17'd86400, ping_step: 17'd86400, ping_limit: 17'd86400,
            backoff_base: 17'd86400, backoff_factor: 6'd32, backoff_max: 17'd86400};
      run_phase(c, 1'b0);
      // base above ceiling, big step after a zero start
      c = '{ping_first: 17'd0, ping_step: 17'd86400, ping_limit: 17'd86400,
            backoff_base: 17'd1000, backoff_factor: 6'd32, backoff_max: 17'd10};
      run_phase(c, 1'b0);
      run_phase(random_cfg(), 1'b0);
      c = '{ping_first: RST_PING_FIRST, ping_step: RST_PING_STEP,
            ping_limit: RST_PING_LIMIT, backoff_base: RST_BACKOFF_BASE,
            backoff_factor: RST_BACKOFF_FACTOR, backoff_max: RST_BACKOFF_MAX};
      run_phase(c, 1'b0);

      drain();
      repeat (20) @(posedge clock);
      if (sup.mismatches == 0)
         $display("** link_keepalive_reconnect_fsm_core: PASSED **");
      else
         $display("** link_keepalive_reconnect_fsm_core: FAILED **");
      $finish;
   end

endmodule
